### src/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg: shared types and constants for the mouse packet tracker
// Register indexes, packet item layout, queue depth and field widths.
// ----------------------------------------------------------------------------
package pmt_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int POS_W          = 12;
   localparam int SIZE_W         = 13;
   localparam int BYTE_W         = 8;
   localparam int BTN_W          = 3;
   localparam int CSR_IDX_W      = 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [BYTE_W-1:0] HEADER_SYNC_BIT = 8'h08;
   localparam logic [BYTE_W-1:0] BUTTON_MASK     = 8'h07;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_VISIBLE = 2'd2;

   localparam int RST_WIDTH  = 1024;
   localparam int RST_HEIGHT = 768;
   localparam int RST_X      = 400;
   localparam int RST_Y      = 300;

   // one complete packet, handed from front to back
   typedef struct packed {
      logic [BTN_W-1:0]  buttons;
      logic [BYTE_W-1:0] delta_x;
      logic [BYTE_W-1:0] delta_y;
   } pmt_pkt_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_DX     = 3'b010,
      PH_DY     = 3'b100
   } pmt_phase_type;

endpackage

### src/pmt_front.sv
// ----------------------------------------------------------------------------
// pmt_front: byte framing
// Takes bytes, resyncs on header bit 3, pushes one packet per third byte.
// ----------------------------------------------------------------------------
module pmt_front import pmt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              q_full,
   output logic              q_push,
   output pmt_pkt_type       q_pkt
);

   pmt_phase_type     phase_ff, phase_in;
   logic [BTN_W-1:0]  btn_ff, btn_in;
   logic [BYTE_W-1:0] dx_ff, dx_in;
   logic              accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      phase_in = phase_ff;
      btn_in   = btn_ff;
      dx_in    = dx_ff;
      q_push   = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_DX: begin
               dx_in    = req_data_byte;
               phase_in = PH_DY;
            end
            PH_DY: begin
               q_push   = 1'b1;
               phase_in = PH_HEADER;
            end
            default: begin
               if ((req_data_byte & HEADER_SYNC_BIT) != '0) begin
                  btn_in   = BTN_W'(req_data_byte & BUTTON_MASK);
                  phase_in = PH_DX;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   assign q_pkt.buttons = btn_ff;
   assign q_pkt.delta_x = dx_ff;
   assign q_pkt.delta_y = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
      btn_ff <= btn_in;
      dx_ff  <= dx_in;
   end

endmodule

### src/pmt_queue.sv
// ----------------------------------------------------------------------------
// pmt_queue: packet queue
// Small register FIFO between the framing front and the cursor back end.
// ----------------------------------------------------------------------------
module pmt_queue import pmt_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  pmt_pkt_type push_pkt,
   input  logic        pop,
   output pmt_pkt_type pop_pkt,
   output logic        full,
   output logic        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pmt_pkt_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_pkt = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_pkt;
      end
   end

endmodule

### src/pmt_back.sv
// ----------------------------------------------------------------------------
// pmt_back: cursor update
// Applies packet deltas, clamps to screen, holds the result register.
// ----------------------------------------------------------------------------
module pmt_back import pmt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  pmt_pkt_type           q_pkt,
   output logic                  q_pop,
   input  logic [COORD_BITS-1:0] lim_x,
   input  logic [COORD_BITS-1:0] lim_y,
   input  logic                  visible,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_W-1:0]      rsp_pos_x,
   output logic [POS_W-1:0]      rsp_pos_y,
   output logic [BTN_W-1:0]      rsp_buttons,
   output logic                  rsp_redraw
);

   localparam int CW    = COORD_BITS;
   localparam int SW    = CW + 2;
   localparam int EXTW  = CW + POS_W;
   localparam int CMAX  = (1 << CW) - 1;
   localparam int RX    = (RST_X > CMAX) ? CMAX : RST_X;
   localparam int RY    = (RST_Y > CMAX) ? CMAX : RST_Y;

   logic [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic              vld_ff, vld_in;
   logic [BTN_W-1:0]  btn_ff;
   logic              redraw_ff;
   logic signed [SW-1:0] sum_x, sum_y;
   logic [EXTW-1:0]   ext_x, ext_y;

   function automatic logic [CW-1:0] clamp(input logic signed [SW-1:0] v,
                                           input logic [CW-1:0] hi);
      logic [CW-1:0] r;
      if (v[SW-1]) begin
         r = '0;
      end else if (v[SW-2:0] > {1'b0, hi}) begin
         r = hi;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   assign q_pop = !q_empty && (!vld_ff || !rsp_stall);

   always_comb begin
      sum_x = $signed({2'b00, cx_ff})
            + $signed({{(SW-BYTE_W){q_pkt.delta_x[BYTE_W-1]}}, q_pkt.delta_x});
      sum_y = $signed({2'b00, cy_ff})
            - $signed({{(SW-BYTE_W){q_pkt.delta_y[BYTE_W-1]}}, q_pkt.delta_y});
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      vld_in = vld_ff && rsp_stall;
      if (q_pop) begin
         cx_in  = clamp(sum_x, lim_x);
         cy_in  = clamp(sum_y, lim_y);
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= CW'(RX);
         cy_ff  <= CW'(RY);
         vld_ff <= 1'b0;
      end else begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         vld_ff <= vld_in;
      end
      if (q_pop) begin
         btn_ff    <= q_pkt.buttons;
         redraw_ff <= visible && ((cx_in != cx_ff) || (cy_in != cy_ff));
      end
   end

   assign ext_x       = {{POS_W{1'b0}}, cx_ff};
   assign ext_y       = {{POS_W{1'b0}}, cy_ff};
   assign rsp_valid   = vld_ff;
   assign rsp_pos_x   = ext_x[POS_W-1:0];
   assign rsp_pos_y   = ext_y[POS_W-1:0];
   assign rsp_buttons = btn_ff;
   assign rsp_redraw  = redraw_ff;

endmodule

### src/ps2_mouse_packet_tracker_unit.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit: mouse packet decoder and cursor tracker
// Frames 3-byte mouse packets, moves and clamps the cursor, reports it.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | data_byte
//   rsp_     | out       | rsp_valid/rsp_stall  | pos_x, pos_y, buttons, redraw
//   csr_     | in        | csr_write_en         | csr_index, csr_write_data
//
// One byte per cycle sustained while the packet queue is not full. A packet's
// third byte is written into a queue slot as it is taken; its result is valid
// once the cursor result register loads from that slot, which waits on rsp_stall.
// req_stall rises only while the two-entry packet queue is full.
// Synchronous reset; no clearing pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit import pmt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [POS_W-1:0]     rsp_pos_x,
   output logic [POS_W-1:0]     rsp_pos_y,
   output logic [BTN_W-1:0]     rsp_buttons,
   output logic                 rsp_redraw,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_write_data
);

   localparam int CW   = COORD_BITS;
   localparam int LW   = 17;
   localparam int CMAX = (1 << CW) - 1;
   localparam int RLX  = (RST_WIDTH - 1 > CMAX) ? CMAX : RST_WIDTH - 1;
   localparam int RLY  = (RST_HEIGHT - 1 > CMAX) ? CMAX : RST_HEIGHT - 1;

   logic [CW-1:0]     lim_x_ff, lim_y_ff;
   logic [CW-1:0]     lim_new;
   logic [LW-1:0]     lim_raw;
   logic              vis_ff;
   logic              q_push, q_pop, q_full, q_empty;
   pmt_pkt_type       push_pkt, pop_pkt;

   // limits are kept precomputed: size 0 acts as 1, then saturate to range
   always_comb begin
      lim_raw = (csr_write_data == '0) ? '0 : LW'(csr_write_data) - 1'b1;
      if (lim_raw > LW'(CMAX)) begin
         lim_new = CW'(CMAX);
      end else begin
         lim_new = lim_raw[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_x_ff <= CW'(RLX);
         lim_y_ff <= CW'(RLY);
         vis_ff   <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:   lim_x_ff <= lim_new;
            CSR_SCREEN_HEIGHT:  lim_y_ff <= lim_new;
            CSR_CURSOR_VISIBLE: vis_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   pmt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_pkt         (push_pkt)
   );

   pmt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_pkt (push_pkt),
      .pop      (q_pop),
      .pop_pkt  (pop_pkt),
      .full     (q_full),
      .empty    (q_empty)
   );

   pmt_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_pkt       (pop_pkt),
      .q_pop       (q_pop),
      .lim_x       (lim_x_ff),
      .lim_y       (lim_y_ff),
      .visible     (vis_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_buttons (rsp_buttons),
      .rsp_redraw  (rsp_redraw)
   );

endmodule

### dv/ps2_mouse_packet_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit_tb: self-checking bench for the packet tracker
// Feeds mouse byte streams (clean packets, junk and broken framing) under
// random valid/stall gaps. A cycle-free cursor tracker in the bench predicts
// each report; every accepted report is compared field by field, in order.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit_tb;
   import pmt_pkg::*;

   localparam int TIMEOUT_CYCLES = 200000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_BYTES    = 160;
   localparam int COORD_LIMIT    = (1 << COORD_BITS_DEF) - 1;
   // index past the last register, must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [BTN_W-1:0] buttons;
      logic             redraw;
   } cursor_report_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_data_byte;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [POS_W-1:0]     rsp_pos_x;
   logic [POS_W-1:0]     rsp_pos_y;
   logic [BTN_W-1:0]     rsp_buttons;
   logic                 rsp_redraw;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_write_data;

   // tracker shadow state
   logic [SIZE_W-1:0] scr_width;
   logic [SIZE_W-1:0] scr_height;
   logic              cur_visible;
   pmt_phase_type     frame_phase;
   logic [BYTE_W-1:0] hdr_byte;
   logic [BYTE_W-1:0] dx_byte;
   int                cur_x;
   int                cur_y;

   cursor_report_type pending_reports[$];
   cursor_report_type want;
   bit             no_gaps;
   int             errors = 0;
   int             reports_checked = 0;
   int             bytes_sent;
   int             reg_writes;
   int             cycle_count = 0;

   ps2_mouse_packet_tracker_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_buttons    (rsp_buttons),
      .rsp_redraw     (rsp_redraw),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("ps2_mouse_packet_tracker_unit: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 33);
   end

   // ---------------- cursor tracker ----------------

   function automatic int clamp_limit(logic [SIZE_W-1:0] size);
      int lim;
      lim = (size == 0) ? 0 : int'(size) - 1;
      return (lim > COORD_LIMIT) ? COORD_LIMIT : lim;
   endfunction

   function automatic int clamp_coord(int v, int hi);
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic void track_byte(logic [BYTE_W-1:0] b);
      int                nx;
      int                ny;
      cursor_report_type rep;
      case (frame_phase)
         PH_DX: begin
            dx_byte     = b;
            frame_phase = PH_DY;
         end
         PH_DY: begin
            frame_phase = PH_HEADER;
            nx = clamp_coord(cur_x + int'($signed(dx_byte)), clamp_limit(scr_width));
            ny = clamp_coord(cur_y - int'($signed(b)), clamp_limit(scr_height));
            rep.pos_x   = nx[POS_W-1:0];
            rep.pos_y   = ny[POS_W-1:0];
            rep.buttons = hdr_byte[BTN_W-1:0] & BUTTON_MASK[BTN_W-1:0];
            rep.redraw  = cur_visible && ((nx != cur_x) || (ny != cur_y));
            cur_x = nx;
            cur_y = ny;
            pending_reports.push_back(rep);
         end
         default: begin
            // header slot: only a byte with the sync bit starts a packet
            if ((b & HEADER_SYNC_BIT) != 0) begin
               hdr_byte    = b;
               frame_phase = PH_DX;
            end else begin
               frame_phase = PH_HEADER;
            end
         end
      endcase
   endfunction

   // ---------------- report checker ----------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("report with no packet pending: x=%0d y=%0d btn=%0d redraw=%0d",
                   rsp_pos_x, rsp_pos_y, rsp_buttons, rsp_redraw);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_pos_x !== want.pos_x) begin
               $error("pos_x: expected %0d, got %0d", want.pos_x, rsp_pos_x);
               errors++;
            end
            if (rsp_pos_y !== want.pos_y) begin
               $error("pos_y: expected %0d, got %0d", want.pos_y, rsp_pos_y);
               errors++;
            end
            if (rsp_buttons !== want.buttons) begin
               $error("buttons: expected %0d, got %0d", want.buttons, rsp_buttons);
               errors++;
            end
            if (rsp_redraw !== want.redraw) begin
               $error("redraw: expected %0d, got %0d", want.redraw, rsp_redraw);
               errors++;
            end
         end
      end
   end

   // ---------------- drivers ----------------

   task automatic send_byte(logic [BYTE_W-1:0] b);
      while (!no_gaps && ($urandom_range(0, 99) < 33)) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid     = 1'b1;
      req_data_byte = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_byte(b);
      bytes_sent++;
   endtask

   task automatic send_packet(logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] dx,
                              logic [BYTE_W-1:0] dy);
      send_byte(hdr);
      send_byte(dx);
      send_byte(dy);
   endtask

   // stop sending and wait until every pending report has come back
   task automatic drain_reports();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      drain_reports();
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = data;
      @(posedge clock);
      case (idx)
         CSR_SCREEN_WIDTH:   scr_width   = data;
         CSR_SCREEN_HEIGHT:  scr_height  = data;
         CSR_CURSOR_VISIBLE: cur_visible = data[0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_screen(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic vis);
      csr_write(CSR_SCREEN_WIDTH, w);
      csr_write(CSR_SCREEN_HEIGHT, h);
      csr_write(CSR_CURSOR_VISIBLE, {{(SIZE_W-1){1'b0}}, vis});
   endtask

   function automatic logic [BYTE_W-1:0] pick_delta(int drift);
      int v;
      case ($urandom_range(0, 15))
         0: return 8'h7F;
         1: return 8'h80;
         default: ;
      endcase
      if (drift > 0) v = $urandom_range(0, 127);
      else if (drift < 0) v = -int'($urandom_range(1, 128));
      else v = $urandom_range(0, 255);
      return v[BYTE_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'd8191;
         4: return SIZE_W'($urandom_range(2, 64));
         5: return SIZE_W'($urandom_range(4097, 8190));
         default: return SIZE_W'($urandom_range(65, 4096));
      endcase
   endfunction

   // ---------------- tests ----------------

   // reset settings: cursor hidden, so no redraw even when moving
   task automatic test_packet_basics();
      send_byte(8'h00);                    // junk in header slot
      send_byte(8'hF7);                    // every bit but sync set: dropped
      send_packet(8'hFF, 8'h80, 8'h7F);    // all buttons, full left and up
      send_packet(8'h08, 8'h00, 8'h00);    // no buttons, no motion
      send_packet(8'h0A, 8'h7F, 8'h80);    // full right and down
      send_packet(8'h0C, 8'h01, 8'hFF);
   endtask

   task automatic test_screen_edges();
      set_screen('0, '0, 1'b1);            // zero size clamps to the origin
      send_packet(8'h09, 8'h05, 8'h05);
      send_packet(8'h09, 8'h05, 8'h05);    // no change: redraw stays low
      csr_write(CSR_UNMAPPED, '1);
      set_screen('1, 13'd4096, 1'b1);      // beyond the coordinate range
      send_packet(8'h0B, 8'h7F, 8'h80);
      set_screen(13'd1, 13'd1, 1'b0);
      send_packet(8'h0E, 8'h7F, 8'h80);
   endtask

   task automatic test_random_traffic();
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      logic              vis;
      int                drift_x;
      int                drift_y;
      int                start;
      bit                paused;
      for (int ph = 0; ph < 6; ph++) begin
         drift_x = 0;
         drift_y = 0;
         case (ph)
            0: begin
               w = '1; h = 13'd4096; vis = 1'b1; drift_x = 1; drift_y = -1;
            end
            1: begin
               w = 13'd1; h = '0; vis = 1'b1;
            end
            2: begin
               w = 13'd40; h = 13'd30; vis = 1'b0; drift_x = -1; drift_y = 1;
            end
            default: begin
               w = pick_size(); h = pick_size(); vis = 1'($urandom_range(0, 1));
               drift_x = int'($urandom_range(0, 2)) - 1;
               drift_y = int'($urandom_range(0, 2)) - 1;
            end
         endcase
         set_screen(w, h, vis);
         no_gaps = (ph == 3);
         start   = bytes_sent;
         paused  = 1'b0;
         while (bytes_sent - start < PHASE_BYTES) begin
            if (!paused && ph == 2 && bytes_sent - start > PHASE_BYTES / 2) begin
               drain_reports();
               paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
               send_packet(BYTE_W'($urandom_range(0, 255)) | HEADER_SYNC_BIT,
                           pick_delta(drift_x), pick_delta(drift_y));
            else
               send_byte(BYTE_W'($urandom_range(0, 255)));
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_SCREEN_WIDTH;
      csr_write_data = '0;
      no_gaps        = 1'b0;
      bytes_sent     = 0;
      reg_writes     = 0;
      scr_width      = SIZE_W'(RST_WIDTH);
      scr_height     = SIZE_W'(RST_HEIGHT);
      cur_visible    = 1'b0;
      frame_phase    = PH_HEADER;
      hdr_byte       = '0;
      dx_byte        = '0;
      cur_x          = (RST_X > COORD_LIMIT) ? COORD_LIMIT : RST_X;
      cur_y          = (RST_Y > COORD_LIMIT) ? COORD_LIMIT : RST_Y;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_packet_basics();
      test_screen_edges();
      test_random_traffic();
      drain_reports();

      $display("run: %0d bytes sent, %0d cursor reports checked, %0d register writes",
               bytes_sent, reports_checked, reg_writes);
      $display("     screen sizes from zero to 8191, cursor shown and hidden, junk bytes mixed in");
      if (errors == 0)
         $display("ps2_mouse_packet_tracker_unit: match");
      else
         $display("ps2_mouse_packet_tracker_unit: mismatch");
      $finish;
   end

endmodule
